[hw/rtl/sm3_pkg.sv]
// SM3 engine shared constants, command struct and bit functions
`default_nettype none
package sm3_pkg;

   localparam int unsigned BlockWords  = 16;
   localparam int unsigned Rounds      = 64;
   localparam int unsigned DigestWords = 8;

   localparam logic [31:0] T_LOW  = 32'h79cc4519;
   localparam logic [31:0] T_HIGH = 32'h7a879d8a;

   localparam logic [31:0] IV [DigestWords] = '{
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
   };

   function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
      logic [63:0] d;
      d = {x, x} << (n % 32);
      return d[63:32];
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rotl(x, 9) ^ rotl(x, 17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rotl(x, 15) ^ rotl(x, 23);
   endfunction

   localparam logic [31:0] T_HIGH_R16 = rotl(T_HIGH, 16);

   typedef struct packed {
      logic load_word;
      logic first;
      logic start;
      logic round;
      logic low_phase;
      logic tj_switch;
      logic feed;
      logic handoff;
      logic out_shift;
   } cmd_type;

endpackage
`default_nettype wire

[hw/rtl/sm3_hash_engine_core.sv]
// SM3 hash engine top level: controller and datapath
//
// Each request carries one padded big-endian message word. A word is taken
// whenever the engine is idle; the sixteenth word of a block starts the
// compression, which runs one round per cycle in a single round unit, then
// a feed-forward step, with the request side stalled throughout. A block
// that ends the message then passes through a hand-off state that copies the
// digest into an output buffer, waiting there while that buffer still holds
// the previous digest. The buffer presents the eight words in order (index 0
// most significant, last_word on index 7) while new requests are already
// taken. A final mark on a word that does not complete a block is ignored;
// without a first mark hashing chains on.
`default_nettype none
module sm3_hash_engine_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_message_word,
   input  wire logic        req_first_word,
   input  wire logic        req_final_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);

   sm3_pkg::cmd_type cmd;

   sm3_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_first_word (req_first_word),
      .req_final_word (req_final_word),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word_index (rsp_word_index),
      .rsp_last_word  (rsp_last_word),
      .cmd            (cmd)
   );

   sm3_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_message_word (req_message_word),
      .rsp_digest_word  (rsp_digest_word)
   );

`ifndef ASSERT_OFF
   a_rounds_stall: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> req_stall)
      else $error("request taken during compression");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_word) |=> !rsp_valid)
      else $error("digest output continued past last word");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_word) |=>
         (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word index did not advance");
`endif

endmodule
`default_nettype wire

[hw/rtl/sm3_ctrl.sv]
// SM3 engine controller: word counting, round sequencing and digest hand-off
`default_nettype none
module sm3_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_first_word,
   input  wire logic            req_final_word,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic [2:0]           rsp_word_index,
   output logic                 rsp_last_word,
   output sm3_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ROUND = 4'b0010,
      ST_FEED  = 4'b0100,
      ST_HAND  = 4'b1000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] word_count_ff, word_count_in;
   logic [5:0] round_ff, round_in;
   logic       final_ff, final_in;
   logic       out_busy_ff, out_busy_in;
   logic [2:0] out_idx_ff, out_idx_in;

   logic       accept;
   logic [3:0] cnt_eff;
   logic       out_take;

   assign req_stall      = (state_ff != ST_IDLE);
   assign accept         = req_valid & ~req_stall;
   assign cnt_eff        = req_first_word ? 4'd0 : word_count_ff;
   assign rsp_valid      = out_busy_ff;
   assign rsp_word_index = out_idx_ff;
   assign rsp_last_word  = (out_idx_ff == 3'(sm3_pkg::DigestWords - 1));
   assign out_take       = out_busy_ff & ~rsp_stall;

   always_comb begin
      state_in      = state_ff;
      word_count_in = word_count_ff;
      round_in      = round_ff;
      final_in      = final_ff;
      out_busy_in   = out_busy_ff;
      out_idx_in    = out_idx_ff;
      cmd           = '0;
      cmd.load_word = accept;
      cmd.first     = accept & req_first_word;
      cmd.low_phase = (round_ff[5:4] == 2'd0);
      cmd.tj_switch = (round_ff == 6'(sm3_pkg::BlockWords - 1));
      cmd.out_shift = out_take;

      if (out_take) begin
         out_idx_in = out_idx_ff + 3'd1;
         if (rsp_last_word) begin
            out_busy_in = 1'b0;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               word_count_in = cnt_eff + 4'd1;
               if (cnt_eff == 4'(sm3_pkg::BlockWords - 1)) begin
                  cmd.start = 1'b1;
                  round_in  = 6'd0;
                  final_in  = req_final_word;
                  state_in  = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            round_in  = round_ff + 6'd1;
            if (round_ff == 6'(sm3_pkg::Rounds - 1)) begin
               state_in = ST_FEED;
            end
         end
         ST_FEED: begin
            cmd.feed = 1'b1;
            state_in = final_ff ? ST_HAND : ST_IDLE;
         end
         ST_HAND: begin
            if (!out_busy_ff) begin
               cmd.handoff = 1'b1;
               out_busy_in = 1'b1;
               out_idx_in  = 3'd0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         word_count_ff <= '0;
         round_ff      <= '0;
         final_ff      <= 1'b0;
         out_busy_ff   <= 1'b0;
         out_idx_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         word_count_ff <= word_count_in;
         round_ff      <= round_in;
         final_ff      <= final_in;
         out_busy_ff   <= out_busy_in;
         out_idx_ff    <= out_idx_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/sm3_dp.sv]
// SM3 engine datapath: message window, round unit, chaining value, digest buffer
`default_nettype none
module sm3_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sm3_pkg::cmd_type  cmd,
   input  wire logic [31:0]       req_message_word,
   output logic [31:0]            rsp_digest_word
);

   logic [31:0] cv_ff   [sm3_pkg::DigestWords];
   logic [31:0] wr_ff   [sm3_pkg::DigestWords];
   logic [31:0] win_ff  [sm3_pkg::BlockWords];
   logic [31:0] obuf_ff [sm3_pkg::DigestWords];
   logic [31:0] tj_ff;

   logic [31:0] w_new, win_tail;
   logic [31:0] a12, ss1, ss2, ffv, ggv, tt1, tt2;

   assign w_new = sm3_pkg::perm1(win_ff[0] ^ win_ff[7] ^ sm3_pkg::rotl(win_ff[13], 15))
                  ^ sm3_pkg::rotl(win_ff[3], 7) ^ win_ff[10];
   assign win_tail = cmd.round ? w_new : req_message_word;

   always_comb begin
      a12 = sm3_pkg::rotl(wr_ff[0], 12);
      ss1 = sm3_pkg::rotl(a12 + wr_ff[4] + tj_ff, 7);
      ss2 = ss1 ^ a12;
      if (cmd.low_phase) begin
         ffv = wr_ff[0] ^ wr_ff[1] ^ wr_ff[2];
         ggv = wr_ff[4] ^ wr_ff[5] ^ wr_ff[6];
      end else begin
         ffv = (wr_ff[0] & wr_ff[1]) | (wr_ff[0] & wr_ff[2]) | (wr_ff[1] & wr_ff[2]);
         ggv = (wr_ff[4] & wr_ff[5]) | (~wr_ff[4] & wr_ff[6]);
      end
      tt1 = ffv + wr_ff[3] + ss2 + (win_ff[0] ^ win_ff[4]);
      tt2 = ggv + wr_ff[7] + ss1 + win_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= sm3_pkg::IV;
      end else if (cmd.first) begin
         cv_ff <= sm3_pkg::IV;
      end else if (cmd.feed) begin
         for (int i = 0; i < sm3_pkg::DigestWords; i++) begin
            cv_ff[i] <= cv_ff[i] ^ wr_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         wr_ff <= cv_ff;
      end else if (cmd.round) begin
         wr_ff[0] <= tt1;
         wr_ff[1] <= wr_ff[0];
         wr_ff[2] <= sm3_pkg::rotl(wr_ff[1], 9);
         wr_ff[3] <= wr_ff[2];
         wr_ff[4] <= sm3_pkg::perm0(tt2);
         wr_ff[5] <= wr_ff[4];
         wr_ff[6] <= sm3_pkg::rotl(wr_ff[5], 19);
         wr_ff[7] <= wr_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         tj_ff <= sm3_pkg::T_LOW;
      end else if (cmd.round) begin
         tj_ff <= cmd.tj_switch ? sm3_pkg::T_HIGH_R16 : sm3_pkg::rotl(tj_ff, 1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_word || cmd.round) begin
         for (int i = 0; i < sm3_pkg::BlockWords - 1; i++) begin
            win_ff[i] <= win_ff[i + 1];
         end
         win_ff[sm3_pkg::BlockWords - 1] <= win_tail;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.handoff) begin
         obuf_ff <= cv_ff;
      end else if (cmd.out_shift) begin
         for (int i = 0; i < sm3_pkg::DigestWords - 1; i++) begin
            obuf_ff[i] <= obuf_ff[i + 1];
         end
         obuf_ff[sm3_pkg::DigestWords - 1] <= obuf_ff[sm3_pkg::DigestWords - 1];
      end
   end

   assign rsp_digest_word = obuf_ff[0];

endmodule
`default_nettype wire

[verif/sm3_hash_engine_core_tb.sv]
// Self-checking testbench for the SM3 hash engine core with an in-bench digest predictor
`timescale 1ns / 1ps
module sm3_hash_engine_core_tb;

   typedef struct {
      bit [31:0] digest;
      bit [2:0]  index;
      bit        last;
   } digest_word_type;

   class digest_scoreboard;
      bit [31:0]       chain_words[8];
      bit [31:0]       blk_words[16];
      bit [3:0]        fill_count;
      digest_word_type expected_digest_q[$];
      int              errors;

      function new();
         load_iv();
         fill_count = 4'd0;
         errors     = 0;
      endfunction

      function void load_iv();
         chain_words = '{32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
                         32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};
      endfunction

      function bit [31:0] rol32(bit [31:0] x, int unsigned n);
         int unsigned k;
         k = n % 32;
         if (k == 0) return x;
         return (x << k) | (x >> (32 - k));
      endfunction

      function bit [31:0] mix0(bit [31:0] x);
         return x ^ rol32(x, 9) ^ rol32(x, 17);
      endfunction

      function bit [31:0] mix1(bit [31:0] x);
         return x ^ rol32(x, 15) ^ rol32(x, 23);
      endfunction

      function void compress_block();
         bit [31:0] w[68];
         bit [31:0] a, b, c, d, e, f, g, h;
         bit [31:0] tj, a12, ss1, ss2, ffv, ggv, tt1, tt2;
         int j;
         for (j = 0; j < 16; j++) w[j] = blk_words[j];
         for (j = 16; j < 68; j++) begin
            w[j] = mix1(w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15)) ^ rol32(w[j-13], 7) ^ w[j-6];
         end
         a = chain_words[0]; b = chain_words[1]; c = chain_words[2]; d = chain_words[3];
         e = chain_words[4]; f = chain_words[5]; g = chain_words[6]; h = chain_words[7];
         for (j = 0; j < 64; j++) begin
            tj  = rol32((j < 16) ? 32'h79cc4519 : 32'h7a879d8a, j);
            a12 = rol32(a, 12);
            ss1 = rol32(a12 + e + tj, 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
               ffv = a ^ b ^ c;
               ggv = e ^ f ^ g;
            end else begin
               ffv = (a & b) | (a & c) | (b & c);
               ggv = (e & f) | (~e & g);
            end
            tt1 = ffv + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = ggv + h + ss1 + w[j];
            d = c;
            c = rol32(b, 9);
            b = a;
            a = tt1;
            h = g;
            g = rol32(f, 19);
            f = e;
            e = mix0(tt2);
         end
         chain_words[0] ^= a; chain_words[1] ^= b; chain_words[2] ^= c; chain_words[3] ^= d;
         chain_words[4] ^= e; chain_words[5] ^= f; chain_words[6] ^= g; chain_words[7] ^= h;
      endfunction

      function void note_request(bit [31:0] word, bit first, bit fin);
         digest_word_type dw;
         int k;
         if (first) begin
            load_iv();
            fill_count = 4'd0;
         end
         blk_words[fill_count] = word;
         fill_count = fill_count + 4'd1;
         if (fill_count != 4'd0) return;
         compress_block();
         if (!fin) return;
         for (k = 0; k < 8; k++) begin
            dw.digest = chain_words[k];
            dw.index  = k[2:0];
            dw.last   = (k == 7);
            expected_digest_q.push_back(dw);
         end
      endfunction

      function void check_response(bit [31:0] digest, bit [2:0] index, bit last);
         digest_word_type dw;
         if (expected_digest_q.size() == 0) begin
            $error("unexpected response: digest_word %h word_index %0d", digest, index);
            errors++;
            return;
         end
         dw = expected_digest_q.pop_front();
         if (digest !== dw.digest) begin
            $error("digest_word mismatch: expected %h, actual %h", dw.digest, digest);
            errors++;
         end
         if (index !== dw.index) begin
            $error("word_index mismatch: expected %0d, actual %0d", dw.index, index);
            errors++;
         end
         if (last !== dw.last) begin
            $error("last_word mismatch: expected %0d, actual %0d", dw.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_digest_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [31:0] req_message_word = 32'd0;
   logic        req_first_word   = 1'b0;
   logic        req_final_word   = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   digest_scoreboard sb = new();

   int burst_left = 0;
   int sent_count = 0;

   sm3_hash_engine_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_message_word (req_message_word),
      .req_first_word   (req_first_word),
      .req_final_word   (req_final_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_word_index   (rsp_word_index),
      .rsp_last_word    (rsp_last_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   // idle between bursts
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 20);
      end
   endtask

   task automatic send_word(input bit [31:0] word, input bit first, input bit fin);
      pace();
      req_valid        <= 1'b1;
      req_message_word <= word;
      req_first_word   <= first;
      req_final_word   <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(word, first, fin);
      sent_count++;
   endtask

   function automatic bit [31:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return 32'h1 << $urandom_range(0, 31);
         3:       return ~(32'h1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   task automatic send_message(input bit with_first, input int blocks);
      int i;
      int total;
      bit fin;
      total = blocks * 16;
      for (i = 0; i < total; i++) begin
         fin = (i == total - 1) || ($urandom_range(0, 15) == 0);
         send_word(pick_word(), with_first && (i == 0), fin);
      end
   endtask

   task automatic send_noise();
      int i;
      int n;
      n = $urandom_range(1, 20);
      for (i = 0; i < n; i++) begin
         send_word(pick_word(), $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
      end
   endtask

   // check responses, then drive the stall pattern with one long hold-off
   initial begin : receiver
      int hold_left;
      int cycle_count;
      int mode_left;
      int stall_mode;
      hold_left   = 0;
      cycle_count = 0;
      mode_left   = 0;
      stall_mode  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.check_response(rsp_digest_word, rsp_word_index, rsp_last_word);
         end
         if (reset) begin
            rsp_stall <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            cycle_count++;
            if (cycle_count == 1500) hold_left = 700;
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(20, 200);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 1) == 1);
               default: rsp_stall <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   initial begin : sender
      int i;
      int kind;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // standard one-block message "abc"
      for (i = 0; i < 16; i++) begin
         send_word((i == 0) ? 32'h6162_6380 : ((i == 15) ? 32'h0000_0018 : 32'h0),
                   i == 0, i == 15);
      end
      // final mark mid-block, then extremes
      send_word(32'hffff_ffff, 1'b1, 1'b1);
      send_word(32'h0000_0000, 1'b0, 1'b0);
      send_word(32'h8000_0000, 1'b0, 1'b1);
      send_word(32'h0000_0001, 1'b0, 1'b0);
      send_word(32'h7fff_ffff, 1'b0, 1'b1);
      send_word(32'hffff_ffff, 1'b0, 1'b0);
      send_word(32'haaaa_aaaa, 1'b0, 1'b1);
      send_word(32'h5555_5555, 1'b0, 1'b0);

      while (sent_count < 460) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            send_message(1'b1, ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(1, 2));
         end else if (kind < 85) begin
            send_message(1'b0, $urandom_range(1, 2));
         end else begin
            send_noise();
         end
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/sm3_pkg.sv
hw/rtl/sm3_ctrl.sv
hw/rtl/sm3_dp.sv
hw/rtl/sm3_hash_engine_core.sv
verif/sm3_hash_engine_core_tb.sv
